@@ src/rwpd_pkg.sv @@
// ----------------------------------------------------------------------------
// rwpd_pkg
// Shared types and codes for the root window pattern detector: sample and
// result payloads, window state, class, pattern and register index codes.
// ----------------------------------------------------------------------------
package rwpd_pkg;

    localparam int TOL_W = 31;
    localparam int VAL_W = 32;

    // sample classes
    localparam logic [1:0] CLS_POS     = 2'd0;
    localparam logic [1:0] CLS_NEG     = 2'd1;
    localparam logic [1:0] CLS_ZERO    = 2'd2;
    localparam logic [1:0] CLS_INVALID = 2'd3;

    // reported patterns
    localparam logic [1:0] PAT_NONE = 2'd0;
    localparam logic [1:0] PAT_ROOT = 2'd1;
    localparam logic [1:0] PAT_SIGN = 2'd2;
    localparam logic [1:0] PAT_EXTR = 2'd3;

    // configuration register indexes
    localparam logic CFG_ZERO_TOL = 1'b0;
    localparam logic CFG_EXTR_TOL = 1'b1;

    typedef struct packed {
        logic signed [VAL_W-1:0] sample_time;
        logic signed [VAL_W-1:0] sample_delta;
        logic                    sample_valid;
    } sample_t;

    typedef struct packed {
        logic        [1:0]       pattern;
        logic signed [VAL_W-1:0] first_time;
        logic signed [VAL_W-1:0] first_delta;
        logic signed [VAL_W-1:0] second_time;
        logic signed [VAL_W-1:0] second_delta;
    } result_t;

    // one stored window point
    typedef struct packed {
        logic [1:0]              cls;
        logic signed [VAL_W-1:0] delta;
        logic signed [VAL_W-1:0] time_val;
    } point_t;

    // previous and one-before points
    typedef struct packed {
        point_t prev;
        point_t old;
    } window_t;

endpackage

@@ src/rwpd_eval.sv @@
// ----------------------------------------------------------------------------
// rwpd_eval
// Classifies a new sample and matches root, sign change and extremum
// patterns against the two stored window points. Pure combinational.
// ----------------------------------------------------------------------------
module rwpd_eval
    import rwpd_pkg::*;
(
    input  sample_t          smp,
    input  window_t          win,
    input  logic [TOL_W-1:0] zero_tol,
    input  logic [TOL_W-1:0] extr_tol,
    output result_t          res,
    output point_t           point
);

    logic signed [VAL_W-1:0] d0;
    logic        [VAL_W:0]   v3;
    logic        [VAL_W:0]   v2;
    logic        [VAL_W:0]   v1;
    logic signed [VAL_W+1:0] d12;
    logic signed [VAL_W+1:0] d13;
    logic signed [VAL_W+1:0] a13;
    logic signed [VAL_W+3:0] d12_x4;
    logic signed [VAL_W+3:0] d13_x;
    logic [1:0]              c0;
    logic                    same_sign;
    logic                    hit;

    // magnitude of a 32-bit value in 33 bits
    function automatic logic [VAL_W:0] mag(input logic signed [VAL_W-1:0] v);
        logic [VAL_W:0] ext;
        ext = {v[VAL_W-1], v};
        mag = v[VAL_W-1] ? ((~ext) + {{VAL_W{1'b0}}, 1'b1}) : ext;
    endfunction

    // classify the new sample, an invalid one keeps zero
    always_comb
    begin
        d0 = smp.sample_valid ? smp.sample_delta : '0;
        v3 = mag(d0);
        if (!smp.sample_valid)
        begin
            c0 = CLS_INVALID;
        end
        else if (v3 <= {2'b00, zero_tol})
        begin
            c0 = CLS_ZERO;
        end
        else
        begin
            c0 = d0[VAL_W-1] ? CLS_NEG : CLS_POS;
        end
    end

    // magnitude differences across the window
    always_comb
    begin
        v2     = mag(win.prev.delta);
        v1     = mag(win.old.delta);
        d12    = $signed({1'b0, v2}) - $signed({1'b0, v1});
        d13    = $signed({1'b0, v3}) - $signed({1'b0, v1});
        a13    = d13[VAL_W+1] ? -d13 : d13;
        d12_x4 = {d12, 2'b00};
        d13_x  = {{2{d13[VAL_W+1]}}, d13};
        same_sign = (c0 == CLS_POS || c0 == CLS_NEG)
                    && win.prev.cls == c0 && win.old.cls == c0;
        hit = ((a13 <= $signed({3'b000, extr_tol})) && d12[VAL_W+1])
              || ((d13 > 0) && (d12_x4 < d13_x));
    end

    // pattern priority: root, sign change, extremum
    always_comb
    begin
        res = '0;
        priority if (c0 == CLS_ZERO)
        begin
            res.pattern      = PAT_ROOT;
            res.first_time   = smp.sample_time;
            res.first_delta  = d0;
            res.second_time  = smp.sample_time;
            res.second_delta = d0;
        end
        else if ((c0 == CLS_POS && win.prev.cls == CLS_NEG)
                 || (c0 == CLS_NEG && win.prev.cls == CLS_POS))
        begin
            res.pattern      = PAT_SIGN;
            res.first_time   = win.prev.time_val;
            res.first_delta  = win.prev.delta;
            res.second_time  = smp.sample_time;
            res.second_delta = d0;
        end
        else if (same_sign && hit)
        begin
            res.pattern      = PAT_EXTR;
            res.first_time   = win.old.time_val;
            res.first_delta  = win.old.delta;
            res.second_time  = smp.sample_time;
            res.second_delta = d0;
        end
        else
        begin
            res = '0;
        end
    end

    // point to shift into the window
    assign point.cls      = c0;
    assign point.delta    = d0;
    assign point.time_val = smp.sample_time;

endmodule

@@ src/root_window_pattern_detector.sv @@
// ----------------------------------------------------------------------------
// root_window_pattern_detector
// Each sample is held in the input register, then its result in the result
// register. Throughput is one sample per cycle while results are not stalled,
// set by the single combinational match stage between the two registers.
// A stalled result holds the input register.
// Reset clears the window to invalid points and both tolerances to 1.
// ----------------------------------------------------------------------------
module root_window_pattern_detector
    import rwpd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             smp_valid,
    output logic             smp_stall,
    input  sample_t          smp_data,
    output logic             det_valid,
    input  logic             det_stall,
    output result_t          det_data,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [TOL_W-1:0] cfg_data
);

    logic             in_full_reg;
    sample_t          in_data_reg;
    logic             out_full_reg;
    result_t          out_data_reg;
    window_t          win_reg;
    window_t          win_next;
    logic [TOL_W-1:0] zero_tol_reg;
    logic [TOL_W-1:0] extr_tol_reg;
    logic             advance;
    result_t          res;
    point_t           point;

    // stage handshake
    assign advance   = in_full_reg && (!out_full_reg || !det_stall);
    assign smp_stall = in_full_reg && !advance;
    assign det_valid = out_full_reg;
    assign det_data  = out_data_reg;

    rwpd_eval u_eval (
        .smp      (in_data_reg),
        .win      (win_reg),
        .zero_tol (zero_tol_reg),
        .extr_tol (extr_tol_reg),
        .res      (res),
        .point    (point)
    );

    // window shift
    always_comb
    begin
        win_next      = win_reg;
        win_next.old  = win_reg.prev;
        win_next.prev = point;
    end

    // control and window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
            win_reg      <= '{prev: '{cls: CLS_INVALID, delta: '0, time_val: '0},
                              old:  '{cls: CLS_INVALID, delta: '0, time_val: '0}};
            zero_tol_reg <= TOL_W'(1);
            extr_tol_reg <= TOL_W'(1);
        end
        else
        begin
            if (smp_valid && !smp_stall)
            begin
                in_full_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_full_reg <= 1'b0;
            end

            if (advance)
            begin
                out_full_reg <= 1'b1;
                win_reg      <= win_next;
            end
            else if (!det_stall)
            begin
                out_full_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ZERO_TOL: zero_tol_reg <= cfg_data;
                    CFG_EXTR_TOL: extr_tol_reg <= cfg_data;
                    default:      zero_tol_reg <= zero_tol_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (smp_valid && !smp_stall)
        begin
            in_data_reg <= smp_data;
        end
        if (advance)
        begin
            out_data_reg <= res;
        end
    end

endmodule

@@ dv/root_window_pattern_detector_tb.sv @@
// ----------------------------------------------------------------------------
// root_window_pattern_detector_tb
// Self-checking bench for the root window pattern detector. Samples go in
// through the valid/stall channel, and the bench keeps its own copy of the
// three-point window to predict the pattern and bracketing pair of every
// sample. Results are matched in order. Directed windows (roots, sign
// changes, extrema, missing samples, full-scale values, tolerance extremes)
// come first, then random walks under several tolerance settings with
// random gaps and back-pressure.
// ----------------------------------------------------------------------------
module root_window_pattern_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rwpd_pkg::*;

    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES  = 5;

    // window predictor and in-order store of expected detections
    class window_scoreboard;
        logic [TOL_W-1:0]        zero_tol;
        logic [TOL_W-1:0]        extr_tol;
        logic [1:0]              past_cls[2];
        logic signed [VAL_W-1:0] past_dlt[2];
        logic signed [VAL_W-1:0] past_tm[2];
        result_t                 detections_q[$];
        int                      errors;
        int                      samples;
        int                      pat_count[4];

        function new();
            zero_tol = 1;
            extr_tol = 1;
            for (int i = 0; i < 2; i++)
            begin
                past_cls[i] = CLS_INVALID;
                past_dlt[i] = '0;
                past_tm[i]  = '0;
            end
            errors  = 0;
            samples = 0;
            for (int i = 0; i < 4; i++)
                pat_count[i] = 0;
        endfunction

        function void write_reg(logic idx, logic [TOL_W-1:0] value);
            if (idx == CFG_ZERO_TOL)
                zero_tol = value;
            else if (idx == CFG_EXTR_TOL)
                extr_tol = value;
        endfunction

        static function longint magnitude(logic signed [VAL_W-1:0] v);
            longint s;
            s = v;
            return (s < 0) ? -s : s;
        endfunction

        // classify the sample, match the window and shift it
        function void note_sample(sample_t s);
            logic [1:0]              c0;
            logic [1:0]              c1;
            logic [1:0]              c2;
            logic signed [VAL_W-1:0] d0;
            result_t                 r;
            longint                  v1, v2, v3, d12, d13, a13;
            bit                      hit;
            d0 = s.sample_delta;
            r  = '0;
            r.pattern = PAT_NONE;
            if (!s.sample_valid)
            begin
                c0 = CLS_INVALID;
                d0 = '0;
            end
            else if (magnitude(d0) <= longint'(zero_tol))
                c0 = CLS_ZERO;
            else
                c0 = (d0 > 0) ? CLS_POS : CLS_NEG;
            c1 = past_cls[0];
            c2 = past_cls[1];

            if (c0 == CLS_ZERO)
            begin
                r.pattern      = PAT_ROOT;
                r.first_time   = s.sample_time;
                r.first_delta  = d0;
                r.second_time  = s.sample_time;
                r.second_delta = d0;
            end
            else if ((c0 == CLS_POS && c1 == CLS_NEG) || (c0 == CLS_NEG && c1 == CLS_POS))
            begin
                r.pattern      = PAT_SIGN;
                r.first_time   = past_tm[0];
                r.first_delta  = past_dlt[0];
                r.second_time  = s.sample_time;
                r.second_delta = d0;
            end
            else if ((c0 == CLS_POS || c0 == CLS_NEG) && c1 == c0 && c2 == c0)
            begin
                v3  = magnitude(d0);
                v2  = magnitude(past_dlt[0]);
                v1  = magnitude(past_dlt[1]);
                d12 = v2 - v1;
                d13 = v3 - v1;
                a13 = (d13 < 0) ? -d13 : d13;
                hit = (a13 <= longint'(extr_tol) && d12 < 0) || (d13 > 0 && 4 * d12 < d13);
                if (hit)
                begin
                    r.pattern      = PAT_EXTR;
                    r.first_time   = past_tm[1];
                    r.first_delta  = past_dlt[1];
                    r.second_time  = s.sample_time;
                    r.second_delta = d0;
                end
            end

            past_cls[1] = past_cls[0];
            past_dlt[1] = past_dlt[0];
            past_tm[1]  = past_tm[0];
            past_cls[0] = c0;
            past_dlt[0] = d0;
            past_tm[0]  = s.sample_time;

            pat_count[r.pattern]++;
            samples++;
            detections_q = {detections_q, r};
        endfunction

        function void compare_field(string name, logic [VAL_W-1:0] expv,
                                    logic [VAL_W-1:0] gotv);
            if (gotv !== expv)
            begin
                $error("%s: expected %h, got %h", name, expv, gotv);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (detections_q.size() == 0)
            begin
                $error("detection with no sample waiting: %h", got);
                errors++;
                return;
            end
            want = detections_q.pop_front();
            compare_field("pattern", VAL_W'(want.pattern), VAL_W'(got.pattern));
            compare_field("first_time", want.first_time, got.first_time);
            compare_field("first_delta", want.first_delta, got.first_delta);
            compare_field("second_time", want.second_time, got.second_time);
            compare_field("second_delta", want.second_delta, got.second_delta);
        endfunction

        function int pending();
            return detections_q.size();
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             smp_valid = 1'b0;
    logic             smp_stall;
    sample_t          smp_data = '0;
    logic             det_valid;
    logic             det_stall = 1'b0;
    result_t          det_data;
    logic             cfg_we = 1'b0;
    logic             cfg_index = CFG_ZERO_TOL;
    logic [TOL_W-1:0] cfg_data = '0;

    window_scoreboard        sb = new();
    bit                      quiet = 1'b0;
    int                      cycles = 0;
    int                      settings = 1;
    longint                  walk_mag = 1000;
    bit                      walk_neg = 1'b0;
    logic signed [VAL_W-1:0] cur_time = '0;

    root_window_pattern_detector dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data),
        .det_valid (det_valid),
        .det_stall (det_stall),
        .det_data  (det_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("root_window_pattern_detector test failed");
            $finish;
        end
    end

    // random back-pressure on the result side
    always @(negedge clk)
        det_stall = !quiet && ($urandom_range(99) < 30);

    // watch register writes, accepted samples and accepted detections
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (smp_valid && !smp_stall)
                sb.note_sample(smp_data);
            if (det_valid && !det_stall)
                sb.check_result(det_data);
        end
    end

    // hand one item to the block, with random gaps in front of it
    task automatic push_sample(input sample_t s);
        while (!quiet && $urandom_range(99) < 30)
        begin
            smp_valid = 1'b0;
            @(negedge clk);
        end
        smp_valid = 1'b1;
        smp_data  = s;
        do
            @(posedge clk);
        while (smp_stall);
        @(negedge clk);
    endtask

    task automatic drive_point(input logic [VAL_W-1:0] t, input logic [VAL_W-1:0] d,
                               input bit v);
        sample_t s;
        s.sample_time  = t;
        s.sample_delta = d;
        s.sample_valid = v;
        push_sample(s);
    endtask

    // stop sending and let every outstanding detection come back
    task automatic drain();
        smp_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic set_tolerances(input logic [TOL_W-1:0] zt, input logic [TOL_W-1:0] et);
        drain();
        cfg_we    = 1'b1;
        cfg_index = CFG_ZERO_TOL;
        cfg_data  = zt;
        @(negedge clk);
        cfg_index = CFG_EXTR_TOL;
        cfg_data  = et;
        @(negedge clk);
        cfg_we = 1'b0;
        settings++;
    endtask

    // random walk of one sign with occasional flips, plus random, near-zero and full-scale values
    function automatic sample_t random_sample();
        sample_t     s;
        int          sel;
        int unsigned span;
        longint      m;
        longint      sm;
        sel = $urandom_range(99);
        if ($urandom_range(9) == 0)
            cur_time = $urandom;
        else
            cur_time = cur_time + $urandom_range(1, 65536);
        s.sample_time  = cur_time;
        s.sample_valid = ($urandom_range(99) >= 5);
        if (sel < 10)
            s.sample_delta = $urandom;
        else if (sel < 15)
        begin
            case ($urandom_range(3))
                0: s.sample_delta = 32'h80000000;
                1: s.sample_delta = 32'h7fffffff;
                2: s.sample_delta = 32'h00000000;
                default: s.sample_delta = 32'hffffffff;
            endcase
        end
        else if (sel < 30)
        begin
            // just around the zero threshold
            m = longint'(sb.zero_tol) + longint'($urandom_range(0, 4)) - 2;
            if (m < 0)
                m = 0;
            if (m > 64'h7fffffff)
                m = 64'h7fffffff;
            sm = $urandom_range(1) ? -m : m;
            s.sample_delta = 32'(sm);
        end
        else
        begin
            if ($urandom_range(99) < 3)
            begin
                case ($urandom_range(2))
                    0: walk_mag = $urandom_range(2, 1000);
                    1: walk_mag = $urandom_range(32'h10000, 32'h1000000);
                    default: walk_mag = $urandom_range(32'h40000000, 32'h7fffffff);
                endcase
            end
            case ($urandom_range(3))
                0: span = 4;
                1: span = 64;
                2: span = 4096;
                default: span = 1 << 20;
            endcase
            m = walk_mag + longint'($urandom_range(0, span)) - longint'(span / 2);
            if (m < 1)
                m = 1;
            if (m > 64'h7fffffff)
                m = 64'h7fffffff;
            walk_mag = m;
            if ($urandom_range(9) == 0)
                walk_neg = !walk_neg;
            sm = walk_neg ? -m : m;
            s.sample_delta = 32'(sm);
        end
        return s;
    endfunction

    initial
    begin
        logic [TOL_W-1:0] phase_zt[NUM_PHASES];
        int               phase_et[NUM_PHASES];
        int               phase_len[NUM_PHASES];

        phase_zt  = '{31'd1, 31'd0, 31'd64, 31'($urandom_range(0, 65536)), 31'h7fffffff};
        phase_et  = '{1, 0, 4096, int'($urandom_range(0, 1 << 20)), 0};
        phase_len = '{200, 200, 200, 200, 50};

        // hold reset, then release it
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset tolerances: roots, sign changes, missing samples
        drive_point(32'h7fffffff, 32'h80000000, 1'b0);
        drive_point(32'h80000000, 32'h00000000, 1'b1);
        drive_point(32'h00010000, 32'h00000001, 1'b1);
        drive_point(32'h00020000, 32'hffffffff, 1'b1);
        drive_point(32'h00030000, 32'h00000002, 1'b1);
        drive_point(32'h00040000, 32'hfffffffe, 1'b1);
        drive_point(32'h00050000, 32'h7fffffff, 1'b1);
        drive_point(32'h00060000, 32'h80000000, 1'b1);
        // missing sample between opposite signs blocks the sign change
        drive_point(32'h00070000, 32'h00000064, 1'b1);
        drive_point(32'h00080000, 32'h12345678, 1'b0);
        drive_point(32'h00090000, 32'hffffff9c, 1'b1);
        // extremum, dip then back within tolerance
        drive_point(32'h000a0000, 32'h00000064, 1'b1);
        drive_point(32'h000b0000, 32'h00000032, 1'b1);
        drive_point(32'h000c0000, 32'h00000065, 1'b1);
        // extremum, fast growth after a flat step, negative side
        drive_point(32'h000d0000, -32'sd1000, 1'b1);
        drive_point(32'h000e0000, -32'sd1001, 1'b1);
        drive_point(32'h000f0000, -32'sd2000, 1'b1);
        // full-scale magnitudes
        drive_point(32'h00100000, 32'h80000000, 1'b1);
        drive_point(32'h00110000, 32'h80000001, 1'b1);
        drive_point(32'h00120000, 32'h80000000, 1'b1);

        // tolerance extremes
        set_tolerances('0, '0);
        drive_point(32'hfffe0000, 32'h00000000, 1'b1);
        drive_point(32'hffff0000, 32'h00000001, 1'b1);
        drive_point(32'h00000000, 32'hffffffff, 1'b1);
        set_tolerances(31'h7fffffff, 31'h7fffffff);
        drive_point(32'h00010000, 32'h7fffffff, 1'b1);
        drive_point(32'h00020000, 32'h80000000, 1'b1);
        drive_point(32'h00030000, 32'h80000000, 1'b1);
        set_tolerances(31'd1, 31'h7fffffff);
        drive_point(32'h00040000, 32'h0000000a, 1'b1);
        drive_point(32'h00050000, 32'h00000005, 1'b1);
        drive_point(32'h00060000, 32'h000003e8, 1'b1);

        // random phases, each under its own tolerances
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_tolerances(phase_zt[p], 31'(phase_et[p]));
            for (int i = 0; i < phase_len[p]; i++)
            begin
                quiet = (p == 2 && i < 150);
                if (p == 1 && i == 100)
                    drain();
                push_sample(random_sample());
            end
        end
        quiet = 1'b0;

        // let the last detections out
        smp_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (LATENCY + 6) @(posedge clk);

        $display("ran %0d samples under %0d tolerance settings in %0d cycles",
                 sb.samples, settings, cycles);
        $display("detections: %0d none, %0d root, %0d sign change, %0d extremum",
                 sb.pat_count[PAT_NONE], sb.pat_count[PAT_ROOT],
                 sb.pat_count[PAT_SIGN], sb.pat_count[PAT_EXTR]);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("root_window_pattern_detector test passed");
        else
            $display("root_window_pattern_detector test failed");
        $finish;
    end

endmodule
